@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the remap core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MNMR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MNMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mnmr_pkg.sv @@
// shared types and constants of the midi note mirror remap core
package mnmr_pkg;

    localparam int NUM_KEYS         = 128;
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int KEY_W            = 7;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 7;

    localparam logic [7:0] CENTER_RESET = 8'd60;
    localparam logic [KEY_W-1:0] KEY_MAX = 7'h7f;

    // message type nibbles
    localparam logic [3:0] TYPE_NOTE_OFF      = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON       = 4'h9;
    localparam logic [3:0] TYPE_POLY_PRESSURE = 4'ha;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_NOTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 1'b1;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] data_one;
        logic [7:0] data_two;
    } t_in;

    typedef struct packed {
        logic [7:0] out_status;
        logic [7:0] out_data_one;
        logic [7:0] out_data_two;
    } t_out;

    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] data;
    } t_wr_req;

endpackage

@@ rtl/core/mnmr_table.sv @@
// key remap table: synchronous memory with init sweep and write forwarding
`include "assert_macros.svh"

module mnmr_table #(
    parameter int NUM_CHANNELS = mnmr_pkg::NUM_CHANNELS_DEF,
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    localparam int ADDR_W = mnmr_pkg::KEY_W + CH_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    input  mnmr_pkg::t_wr_req            i_wr,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    output logic [mnmr_pkg::KEY_W-1:0]   o_rd_data,
    output logic                         o_busy
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [mnmr_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [mnmr_pkg::KEY_W-1:0] r_rd;
    logic [ADDR_W-1:0]          r_rd_addr;
    logic                       r_busy;
    logic [ADDR_W-1:0]          r_clr_addr;
    logic                       r_fwd_valid;
    logic [ADDR_W-1:0]          r_fwd_addr;
    logic [mnmr_pkg::KEY_W-1:0] r_fwd_data;

    // init sweep: every entry gets its own key (the upper address bits)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= r_clr_addr[ADDR_W-1 -: mnmr_pkg::KEY_W];
        end else if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd      <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // last write is always at least as new as the held read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (!r_busy && i_wr.en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_wr.en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_rd_data = (r_fwd_valid && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd;
    assign o_busy    = r_busy;

    `MNMR_ASSERT_IMPL(a_no_read_in_init, i_clk, i_rst_n, r_busy, !i_rd_en,
        "table read during init sweep")
    `MNMR_ASSERT_IMPL(a_no_fwd_after_init, i_clk, i_rst_n, $fell(r_busy), !r_fwd_valid,
        "forwarding entry live at end of init sweep")

endmodule

@@ rtl/core/mnmr_decode.sv @@
// message classify, key mirror and table update decision
module mnmr_decode #(
    parameter int NUM_CHANNELS = mnmr_pkg::NUM_CHANNELS_DEF
) (
    input  mnmr_pkg::t_in               i_item,
    input  logic [mnmr_pkg::KEY_W-1:0]  i_entry,
    input  logic [mnmr_pkg::KEY_W-1:0]  i_center,
    input  logic                        i_enable,
    output mnmr_pkg::t_out              o_result,
    output mnmr_pkg::t_wr_req           o_wr
);

    logic [3:0]                 msg_type;
    logic [3:0]                 chan;
    logic [mnmr_pkg::KEY_W-1:0] key;
    logic                       vel_zero;
    logic                       in_range;
    logic                       note_on;
    logic                       note_off;
    logic                       poly;
    logic [8:0]                 diff;
    logic [mnmr_pkg::KEY_W-1:0] mirror;

    assign msg_type = i_item.status_byte[7:4];
    assign chan     = i_item.status_byte[3:0];
    assign key      = i_item.data_one[6:0];
    assign vel_zero = (i_item.data_two[6:0] == 7'd0);
    assign in_range = ({1'b0, chan} < 5'(NUM_CHANNELS));

    assign note_on  = (msg_type == mnmr_pkg::TYPE_NOTE_ON) && !vel_zero;
    assign note_off = (msg_type == mnmr_pkg::TYPE_NOTE_OFF) ||
                      ((msg_type == mnmr_pkg::TYPE_NOTE_ON) && vel_zero);
    assign poly     = (msg_type == mnmr_pkg::TYPE_POLY_PRESSURE);

    // 2*center - key, clamped to 0..127
    assign diff = {1'b0, i_center, 1'b0} - {2'b00, key};
    always_comb begin
        if (diff[8]) begin
            mirror = '0;
        end else if (diff[7]) begin
            mirror = mnmr_pkg::KEY_MAX;
        end else begin
            mirror = diff[6:0];
        end
    end

    always_comb begin
        o_result.out_status   = i_item.status_byte;
        o_result.out_data_two = i_item.data_two;
        o_result.out_data_one = i_item.data_one;
        o_wr.en   = 1'b0;
        o_wr.data = key;
        if (in_range) begin
            if (note_off) begin
                o_result.out_data_one = {1'b0, i_entry};
                o_wr.en   = 1'b1;
                o_wr.data = key;
            end else if (i_enable && (note_on || poly)) begin
                o_result.out_data_one = {1'b0, mirror};
                o_wr.en   = note_on;
                o_wr.data = mirror;
            end
        end
    end

endmodule

@@ rtl/core/midi_note_mirror_remap_top.sv @@
// top level of the midi note mirror remap core
// After reset the block sweeps all NUM_KEYS * 2**CH_W entries of its key remap
// table once, one entry per cycle, CH_W being the channel index width of at least
// one bit (2048 entries with 16 channels);
// o_stall stays high during the sweep while configuration writes are still
// taken. From then on it takes one message per cycle while the output is not
// stalled and gives one result per message, registered in the table stage and
// then in the output register. The rate comes from the single table memory: each
// message is read on input transfer and written back one stage later, with the
// last write forwarded so back-to-back messages on the same key and channel see it.
`include "assert_macros.svh"

module midi_note_mirror_remap_top #(
    parameter int NUM_CHANNELS = mnmr_pkg::NUM_CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  mnmr_pkg::t_in                     i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output mnmr_pkg::t_out                    o_data,
    input  logic                              i_cfg_we,
    input  logic [mnmr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mnmr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ADDR_W = mnmr_pkg::KEY_W + CH_W;

    logic [mnmr_pkg::KEY_W-1:0] r_center;
    logic                       r_enable;
    logic                       r_s1_valid;
    mnmr_pkg::t_in              r_s1_item;
    logic [ADDR_W-1:0]          r_s1_addr;
    logic                       r_out_valid;
    mnmr_pkg::t_out             r_out;

    logic                       n_s1_valid;
    logic                       n_out_valid;
    logic                       in_acc;
    logic                       s1_adv;
    logic                       busy;
    logic [ADDR_W-1:0]          rd_addr;
    logic [mnmr_pkg::KEY_W-1:0] entry;
    mnmr_pkg::t_out             result;
    mnmr_pkg::t_wr_req          dec_wr;
    mnmr_pkg::t_wr_req          tbl_wr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= mnmr_pkg::CENTER_RESET[mnmr_pkg::KEY_W-1:0];
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mnmr_pkg::REG_CENTER_NOTE: r_center <= i_cfg_data[mnmr_pkg::KEY_W-1:0];
                mnmr_pkg::REG_ENABLE:      r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = busy || (r_s1_valid && !s1_adv);
    assign in_acc  = i_valid && !o_stall;
    assign rd_addr = {i_data.data_one[mnmr_pkg::KEY_W-1:0], i_data.status_byte[CH_W-1:0]};

    assign tbl_wr.en   = s1_adv && dec_wr.en;
    assign tbl_wr.data = dec_wr.data;

    mnmr_table #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .i_wr      (tbl_wr),
        .i_wr_addr (r_s1_addr),
        .o_rd_data (entry),
        .o_busy    (busy)
    );

    mnmr_decode #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_decode (
        .i_item   (r_s1_item),
        .i_entry  (entry),
        .i_center (r_center),
        .i_enable (r_enable),
        .o_result (result),
        .o_wr     (dec_wr)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_data;
            r_s1_addr <= rd_addr;
        end
        if (s1_adv) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `MNMR_ASSERT_NEXT(a_acc_fills_s1, i_clk, i_rst_n, in_acc, r_s1_valid,
        "accepted transfer did not reach the table stage")
    `MNMR_ASSERT_IMPL(a_out_from_s1, i_clk, i_rst_n, $rose(r_out_valid), $past(r_s1_valid),
        "result appeared without a message in the table stage")

endmodule

@@ tb/sv/midi_note_mirror_remap_top_tb.sv @@
// testbench of the midi note mirror remap core: directed and random midi traffic
`timescale 1ns / 1ps

module midi_note_mirror_remap_top_tb;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 250;
    localparam int TAIL_CYCLES = 10;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_valid    = 1'b0;
    logic                            i_stall    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [mnmr_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [mnmr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    mnmr_pkg::t_in                   i_data     = '0;
    logic                            o_stall;
    logic                            o_valid;
    mnmr_pkg::t_out                  o_data;

    // own copy of the remap state and registers
    logic [mnmr_pkg::KEY_W-1:0] remap_mem [0:mnmr_pkg::NUM_KEYS*16-1];
    logic [mnmr_pkg::KEY_W-1:0] cur_center;
    logic                       cur_enable;

    mnmr_pkg::t_out expected_results [$];
    logic [10:0]    held_notes [$];
    int             sender_idle_pct = 0;
    int             receiver_stall_pct = 0;
    int             mismatch_count = 0;
    int             cycle_count = 0;

    midi_note_mirror_remap_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
    end

    function automatic mnmr_pkg::t_out predict_remap(input mnmr_pkg::t_in m);
        mnmr_pkg::t_out             r;
        logic [3:0]                 kind;
        logic [3:0]                 chan;
        logic [mnmr_pkg::KEY_W-1:0] key;
        logic [mnmr_pkg::KEY_W-1:0] vel;
        logic [10:0]                slot;
        int                         mirrored;
        kind = m.status_byte[7:4];
        chan = m.status_byte[3:0];
        key  = m.data_one[6:0];
        vel  = m.data_two[6:0];
        r.out_status   = m.status_byte;
        r.out_data_one = m.data_one;
        r.out_data_two = m.data_two;
        // note-on with zero velocity is a note-off
        if (kind == mnmr_pkg::TYPE_NOTE_ON && vel == '0) kind = mnmr_pkg::TYPE_NOTE_OFF;
        slot = {key, chan};
        mirrored = 2 * int'(cur_center) - int'(key);
        if (mirrored > 127) mirrored = 127;
        if (mirrored < 0) mirrored = 0;
        if (cur_enable && (kind == mnmr_pkg::TYPE_NOTE_ON ||
                           kind == mnmr_pkg::TYPE_POLY_PRESSURE)) begin
            r.out_data_one = {1'b0, 7'(mirrored)};
            if (kind == mnmr_pkg::TYPE_NOTE_ON) remap_mem[slot] = 7'(mirrored);
        end
        if (kind == mnmr_pkg::TYPE_NOTE_OFF) begin
            r.out_data_one = {1'b0, remap_mem[slot]};
            remap_mem[slot] = key;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin : result_check
        mnmr_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_data));
            end else begin
                want = expected_results.pop_front();
                if (o_data.out_status !== want.out_status)
                    report_mismatch($sformatf("out_status expected %h got %h",
                        want.out_status, o_data.out_status));
                if (o_data.out_data_one !== want.out_data_one)
                    report_mismatch($sformatf("out_data_one expected %h got %h",
                        want.out_data_one, o_data.out_data_one));
                if (o_data.out_data_two !== want.out_data_two)
                    report_mismatch($sformatf("out_data_two expected %h got %h",
                        want.out_data_two, o_data.out_data_two));
            end
        end
    end

    function automatic mnmr_pkg::t_in build_msg(input logic [7:0] st, input logic [7:0] d1,
                                                input logic [7:0] d2);
        mnmr_pkg::t_in m;
        m.status_byte = st;
        m.data_one    = d1;
        m.data_two    = d2;
        return m;
    endfunction

    // called at a clock edge; leaves valid high after the transfer
    task automatic send_msg(input mnmr_pkg::t_in m);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.insert(expected_results.size(), predict_remap(m));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // only while idle
    task automatic write_reg(input logic [mnmr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mnmr_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mnmr_pkg::REG_CENTER_NOTE) cur_center = value[mnmr_pkg::KEY_W-1:0];
        else if (idx == mnmr_pkg::REG_ENABLE) cur_enable = value[0];
        @(posedge i_clk);
    endtask

    function automatic mnmr_pkg::t_in make_random_msg();
        mnmr_pkg::t_in m;
        logic [3:0]    chan;
        logic [6:0]    key;
        logic [7:0]    d1;
        logic [7:0]    d2;
        logic [10:0]   note;
        int            pick;
        int            r;
        chan = ($urandom_range(99) < 60) ? 4'($urandom_range(0, 2)) : 4'($urandom_range(0, 15));
        key  = ($urandom_range(99) < 60) ? 7'($urandom_range(56, 71))
                                         : 7'($urandom_range(0, 127));
        d1 = {($urandom_range(99) < 10) ? 1'b1 : 1'b0, key};
        d2 = 8'($urandom_range(0, 255));
        r = $urandom_range(99);
        if (r < 35) begin
            // note-on with nonzero velocity
            if (d2[6:0] == '0) d2[0] = 1'b1;
            m = build_msg({mnmr_pkg::TYPE_NOTE_ON, chan}, d1, d2);
            if (held_notes.size() < 64) held_notes.insert(held_notes.size(), {key, chan});
        end else if (r < 60) begin
            // release, in most cases of a held note when there is one
            if (held_notes.size() != 0 && $urandom_range(99) < 80) begin
                pick = $urandom_range(0, held_notes.size() - 1);
                note = held_notes[pick];
                held_notes.delete(pick);
                chan = note[3:0];
                d1   = {d1[7], note[10:4]};
            end
            if ($urandom_range(99) < 30)
                m = build_msg({mnmr_pkg::TYPE_NOTE_ON, chan}, d1, {d2[7], 7'h00});
            else
                m = build_msg({mnmr_pkg::TYPE_NOTE_OFF, chan}, d1, d2);
        end else if (r < 72) begin
            m = build_msg({mnmr_pkg::TYPE_POLY_PRESSURE, chan}, d1, d2);
        end else begin
            m = mnmr_pkg::t_in'(24'($urandom()));
        end
        return m;
    endfunction

    task automatic test_reset_mirror();
        send_msg(build_msg(8'h90, 8'd60, 8'd100));
        send_msg(build_msg(8'h9f, 8'd0, 8'd127));
        send_msg(build_msg(8'h93, 8'd127, 8'd1));
        send_msg(build_msg(8'h8f, 8'd0, 8'd64));
        send_msg(build_msg(8'h93, 8'd127, 8'd0));
        send_msg(build_msg(8'h85, 8'd10, 8'd0));
        send_msg(build_msg(8'h80, 8'd60, 8'd0));
        drain_results();
    endtask

    task automatic test_edge_cases();
        write_reg(mnmr_pkg::REG_CENTER_NOTE, 7'd0);
        // key byte with bit 7 set, velocity 0x80 counts as zero
        send_msg(build_msg(8'h91, 8'hff, 8'hff));
        send_msg(build_msg(8'ha1, 8'd5, 8'h80));
        send_msg(build_msg(8'h91, 8'd5, 8'h80));
        drain_results();
        write_reg(mnmr_pkg::REG_CENTER_NOTE, 7'd127);
        send_msg(build_msg(8'h92, 8'd0, 8'h40));
        send_msg(build_msg(8'ha2, 8'd127, 8'h7f));
        drain_results();
        // disabled: note-off still restores the stored key
        write_reg(mnmr_pkg::REG_ENABLE, 7'd0);
        send_msg(build_msg(8'h92, 8'd0, 8'h40));
        send_msg(build_msg(8'h82, 8'h80, 8'h00));
        send_msg(build_msg(8'ha2, 8'd3, 8'h10));
        send_msg(build_msg(8'hb0, 8'h7f, 8'h7f));
        send_msg(build_msg(8'hc5, 8'haa, 8'h55));
        send_msg(build_msg(8'hf0, 8'hff, 8'hff));
        send_msg(build_msg(8'hff, 8'h00, 8'h00));
        send_msg(build_msg(8'h00, 8'h80, 8'h80));
        send_msg(build_msg(8'h8e, 8'hff, 8'h00));
        drain_results();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [6:0] center, input logic en);
        drain_results();
        write_reg(mnmr_pkg::REG_CENTER_NOTE, center);
        write_reg(mnmr_pkg::REG_ENABLE, {6'd0, en});
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_msg(make_random_msg());
            // hold off the sender until the output side has caught up
            if (i == PHASE_ITEMS / 2) drain_results();
        end
        drain_results();
    endtask

    initial begin
        for (int s = 0; s < mnmr_pkg::NUM_KEYS * 16; s++) remap_mem[s] = 7'(s >> 4);
        cur_center = mnmr_pkg::CENTER_RESET[mnmr_pkg::KEY_W-1:0];
        cur_enable = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_mirror();
        test_edge_cases();
        test_random_phase(0, 0, 7'd60, 1'b1);
        test_random_phase(58, 0, 7'd0, 1'b1);
        test_random_phase(0, 58, 7'd127, 1'b1);
        test_random_phase(6, 6, 7'($urandom_range(0, 127)), 1'b0);
        test_random_phase(0, 0, 7'd64, 1'b1);
        test_random_phase(58, 0, 7'd127, 1'b0);
        test_random_phase(0, 58, 7'($urandom_range(0, 127)), 1'b1);
        test_random_phase(6, 6, 7'd0, 1'b1);

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mnmr_pkg.sv
rtl/core/mnmr_table.sv
rtl/core/mnmr_decode.sv
rtl/core/midi_note_mirror_remap_top.sv
tb/sv/midi_note_mirror_remap_top_tb.sv
